FILE: sv/hbfp_pkg.sv
// hbfp_pkg: types and constants shared by the header block field parser
// no dependencies; every other file of the block but the two interfaces refers to it by scoped names
`default_nettype none

package hbfp_pkg;

   // parse phase of the byte-level state machine
   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_NAME_LEN    = 3'd1,
      PH_NAME_BYTES  = 3'd2,
      PH_VALUE_LEN   = 3'd3,
      PH_VALUE_BYTES = 3'd4
   } phase_type;

   // kind of event carried by a result word
   typedef enum logic [2:0] {
      KIND_INDEXED    = 3'd0,
      KIND_NAME_REF   = 3'd1,
      KIND_NAME_BYTE  = 3'd2,
      KIND_VALUE_BYTE = 3'd3,
      KIND_EMPTY      = 3'd4,
      KIND_ERROR      = 3'd5
   } kind_type;

   // representation of a header field
   typedef enum logic [1:0] {
      FORM_INDEXED     = 2'd0,
      FORM_INCREMENTAL = 2'd1,
      FORM_WITHOUT     = 2'd2,
      FORM_NEVER       = 2'd3
   } form_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_INDEX = 3'd1,
      ERR_HUFFMAN   = 3'd2,
      ERR_PREFIX    = 3'd3,
      ERR_CONTINUE  = 3'd4,
      ERR_TRUNCATED = 3'd5
   } err_type;

   localparam int COUNTER_W = 16;
   localparam int LENGTH_W  = 7;

   // queue between the parser and the output stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // event record produced by the parser, before output formatting
   typedef struct packed {
      kind_type               kind;
      form_type               form;
      logic [5:0]             name_index;
      logic [COUNTER_W-1:0]   counter;
      logic [7:0]             str_byte;
      logic                   str_end;
      err_type                err;
   } event_type;

   // queue read side as seen by the output stage
   typedef struct packed {
      logic      valid;
      event_type data;
   } queue_head_type;

endpackage

`default_nettype wire

FILE: sv/hbfp_req_if.sv
// hbfp_req_if: input channel of the header block field parser, one byte a word
// depends on nothing; valid/ready handshake with source and sink modports
`default_nettype none

interface hbfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] block_byte;
   logic       block_last;

   modport source (output valid, output block_byte, output block_last, input ready);
   modport sink   (input valid, input block_byte, input block_last, output ready);
endinterface

`default_nettype wire

FILE: sv/hbfp_rsp_if.sv
// hbfp_rsp_if: result channel of the header block field parser, one event a word
// depends on nothing; valid/ready handshake with source and sink modports
`default_nettype none

interface hbfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [1:0]  field_form;
   logic [5:0]  static_index;
   logic [15:0] assigned_index;
   logic [7:0]  string_byte;
   logic        string_end;
   logic [2:0]  error_code;

   modport source (output valid, output event_kind, output field_form, output static_index,
                   output assigned_index, output string_byte, output string_end,
                   output error_code, input ready);
   modport sink   (input valid, input event_kind, input field_form, input static_index,
                   input assigned_index, input string_byte, input string_end,
                   input error_code, output ready);
endinterface

`default_nettype wire

FILE: sv/hbfp_front.sv
// hbfp_front: byte-level parser; classifies each accepted byte and builds an event record
// depends on hbfp_pkg and hbfp_req_if
`default_nettype none

module hbfp_front #(
   parameter int STATIC_ENTRIES = 61
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   hbfp_req_if.sink                           req_bus,
   input  wire logic                          queue_full,
   input  wire logic                          csr_wr_en,
   input  wire logic [hbfp_pkg::COUNTER_W-1:0] csr_wr_data,
   output logic                               push,
   output hbfp_pkg::event_type                push_data
);

   localparam logic [6:0] INDEX_MAX = 7'(STATIC_ENTRIES);

   hbfp_pkg::phase_type                    phase_ff, phase_in;
   logic [hbfp_pkg::LENGTH_W-1:0]          remaining_ff, remaining_in;
   hbfp_pkg::form_type                     form_ff, form_in;
   logic [5:0]                             name_ff, name_in;
   logic [hbfp_pkg::COUNTER_W-1:0]         counter_ff, counter_in;
   logic                                   hold_ff, hold_in;

   logic                                   accept;
   logic [7:0]                             b;
   logic                                   last;
   logic                                   is_indexed;
   logic                                   is_incremental;
   logic                                   is_literal4;
   hbfp_pkg::form_type                     lit_form;
   logic [5:0]                             lit_index;
   logic [hbfp_pkg::LENGTH_W-1:0]          remaining_dec;
   hbfp_pkg::err_type                      prefix_err;
   hbfp_pkg::err_type                      length_err;
   hbfp_pkg::err_type                      step_err;
   hbfp_pkg::phase_type                    phase_step;

   // no word is taken while reset is high
   assign req_bus.ready = !queue_full && !reset;
   assign accept        = req_bus.valid && !queue_full && !reset;
   assign b             = req_bus.block_byte;
   assign last          = req_bus.block_last;

   // prefix and length byte decode
   always_comb begin
      is_indexed     = b[7];
      is_incremental = (b[7:6] == 2'b01);
      is_literal4    = (b[7:5] == 3'b000);
      lit_form       = is_incremental ? hbfp_pkg::FORM_INCREMENTAL
                     : (b[4] ? hbfp_pkg::FORM_NEVER : hbfp_pkg::FORM_WITHOUT);
      lit_index      = is_incremental ? b[5:0] : {2'b00, b[3:0]};
      remaining_dec  = remaining_ff - 7'd1;

      priority if (is_indexed) begin
         if (b[6:0] == 7'h7F)
            prefix_err = hbfp_pkg::ERR_CONTINUE;
         else if (b[6:0] == 7'd0 || b[6:0] > INDEX_MAX)
            prefix_err = hbfp_pkg::ERR_BAD_INDEX;
         else
            prefix_err = hbfp_pkg::ERR_NONE;
      end else if (is_incremental) begin
         if (b[5:0] == 6'h3F)
            prefix_err = hbfp_pkg::ERR_CONTINUE;
         else if ({1'b0, b[5:0]} > INDEX_MAX)
            prefix_err = hbfp_pkg::ERR_BAD_INDEX;
         else
            prefix_err = hbfp_pkg::ERR_NONE;
      end else if (is_literal4) begin
         if (b[3:0] == 4'hF)
            prefix_err = hbfp_pkg::ERR_CONTINUE;
         else if ({3'b000, b[3:0]} > INDEX_MAX)
            prefix_err = hbfp_pkg::ERR_BAD_INDEX;
         else
            prefix_err = hbfp_pkg::ERR_NONE;
      end else begin
         prefix_err = hbfp_pkg::ERR_PREFIX;
      end

      priority if (b[7])
         length_err = hbfp_pkg::ERR_HUFFMAN;
      else if (b[6:0] == 7'h7F)
         length_err = hbfp_pkg::ERR_CONTINUE;
      else
         length_err = hbfp_pkg::ERR_NONE;
   end

   // error of this byte and the phase it leads to when no error occurs
   always_comb begin
      step_err   = hbfp_pkg::ERR_NONE;
      phase_step = phase_ff;
      unique case (phase_ff)
         hbfp_pkg::PH_IDLE: begin
            step_err = prefix_err;
            if (!is_indexed)
               phase_step = (lit_index != 6'd0) ? hbfp_pkg::PH_VALUE_LEN
                                                : hbfp_pkg::PH_NAME_LEN;
         end
         hbfp_pkg::PH_NAME_LEN: begin
            step_err   = length_err;
            phase_step = (b[6:0] == 7'd0) ? hbfp_pkg::PH_VALUE_LEN : hbfp_pkg::PH_NAME_BYTES;
         end
         hbfp_pkg::PH_VALUE_LEN: begin
            step_err   = length_err;
            phase_step = (b[6:0] == 7'd0) ? hbfp_pkg::PH_IDLE : hbfp_pkg::PH_VALUE_BYTES;
         end
         hbfp_pkg::PH_NAME_BYTES: begin
            if (remaining_dec == 7'd0)
               phase_step = hbfp_pkg::PH_VALUE_LEN;
         end
         hbfp_pkg::PH_VALUE_BYTES: begin
            if (remaining_dec == 7'd0)
               phase_step = hbfp_pkg::PH_IDLE;
         end
         default: begin
            phase_step = hbfp_pkg::PH_IDLE;
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      form_in      = form_ff;
      name_in      = name_ff;
      counter_in   = counter_ff;
      hold_in      = hold_ff;

      if (accept) begin
         if (hold_ff) begin
            // drop bytes up to the end of the block after an error
            if (last) begin
               hold_in  = 1'b0;
               phase_in = hbfp_pkg::PH_IDLE;
            end
         end else if (step_err != hbfp_pkg::ERR_NONE) begin
            phase_in = hbfp_pkg::PH_IDLE;
            hold_in  = !last;
         end else begin
            phase_in = last ? hbfp_pkg::PH_IDLE : phase_step;
            unique case (phase_ff)
               hbfp_pkg::PH_IDLE: begin
                  if (!is_indexed) begin
                     form_in = lit_form;
                     name_in = lit_index;
                     if (is_incremental)
                        counter_in = counter_ff + 16'd1;
                  end
               end
               hbfp_pkg::PH_NAME_LEN, hbfp_pkg::PH_VALUE_LEN: begin
                  if (b[6:0] != 7'd0)
                     remaining_in = b[6:0];
               end
               hbfp_pkg::PH_NAME_BYTES, hbfp_pkg::PH_VALUE_BYTES: begin
                  remaining_in = remaining_dec;
               end
               default: begin
                  phase_in = hbfp_pkg::PH_IDLE;
               end
            endcase
         end
      end

      // start value of the counter
      if (csr_wr_en)
         counter_in = csr_wr_data;
   end

   // event record for the queue
   always_comb begin
      logic              have;
      logic              trunc;
      hbfp_pkg::kind_type kind;

      have  = 1'b0;
      kind  = hbfp_pkg::KIND_ERROR;
      trunc = last && (phase_step != hbfp_pkg::PH_IDLE);

      unique case (phase_ff)
         hbfp_pkg::PH_IDLE: begin
            if (is_indexed) begin
               have = 1'b1;
               kind = hbfp_pkg::KIND_INDEXED;
            end else if (lit_index != 6'd0) begin
               have = 1'b1;
               kind = hbfp_pkg::KIND_NAME_REF;
            end
         end
         hbfp_pkg::PH_NAME_LEN: begin
            have = 1'b0;
         end
         hbfp_pkg::PH_VALUE_LEN: begin
            if (b[6:0] == 7'd0) begin
               have = 1'b1;
               kind = hbfp_pkg::KIND_EMPTY;
            end
         end
         hbfp_pkg::PH_NAME_BYTES: begin
            have = 1'b1;
            kind = hbfp_pkg::KIND_NAME_BYTE;
         end
         hbfp_pkg::PH_VALUE_BYTES: begin
            have = 1'b1;
            kind = hbfp_pkg::KIND_VALUE_BYTE;
         end
         default: begin
            have  = 1'b0;
            trunc = 1'b0;
         end
      endcase

      push_data.kind       = have ? kind : hbfp_pkg::KIND_ERROR;
      push_data.form       = (phase_ff == hbfp_pkg::PH_IDLE && is_indexed)
                           ? hbfp_pkg::FORM_INDEXED : form_in;
      push_data.name_index = (phase_ff == hbfp_pkg::PH_IDLE && is_indexed)
                           ? b[5:0] : name_in;
      push_data.counter    = counter_in;
      push_data.str_byte   = (kind == hbfp_pkg::KIND_NAME_BYTE
                              || kind == hbfp_pkg::KIND_VALUE_BYTE) ? b : 8'd0;
      push_data.str_end    = (kind == hbfp_pkg::KIND_NAME_BYTE
                              || kind == hbfp_pkg::KIND_VALUE_BYTE)
                              && (remaining_dec == 7'd0);
      push_data.err        = hbfp_pkg::ERR_NONE;
      push                 = 1'b0;

      if (accept && !hold_ff) begin
         if (step_err != hbfp_pkg::ERR_NONE) begin
            push           = 1'b1;
            push_data.kind = hbfp_pkg::KIND_ERROR;
            push_data.err  = step_err;
         end else if (have || trunc) begin
            push          = 1'b1;
            push_data.err = trunc ? hbfp_pkg::ERR_TRUNCATED : hbfp_pkg::ERR_NONE;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hbfp_pkg::PH_IDLE;
         remaining_ff <= '0;
         form_ff      <= hbfp_pkg::FORM_INDEXED;
         name_ff      <= '0;
         counter_ff   <= '0;
         hold_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         form_ff      <= form_in;
         name_ff      <= name_in;
         counter_ff   <= counter_in;
         hold_ff      <= hold_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/hbfp_queue.sv
// hbfp_queue: short first-in first-out queue of event records between parser and output
// depends on hbfp_pkg
`default_nettype none

module hbfp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  hbfp_pkg::event_type       push_data,
   input  wire logic                 pop,
   output logic                      full,
   output hbfp_pkg::queue_head_type  head
);

   hbfp_pkg::event_type                entry_ff [hbfp_pkg::QUEUE_DEPTH];
   logic [hbfp_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [hbfp_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [hbfp_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign full       = (count_ff == hbfp_pkg::QCNT_W'(hbfp_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? hbfp_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? hbfp_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

FILE: sv/hbfp_back.sv
// hbfp_back: output stage; formats queued event records into result words
// depends on hbfp_pkg and hbfp_rsp_if
`default_nettype none

module hbfp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  hbfp_pkg::queue_head_type  head,
   output logic                      pop,
   hbfp_rsp_if.source                rsp_bus
);

   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [1:0]  form_ff, form_in;
   logic [5:0]  index_ff, index_in;
   logic [15:0] assigned_ff, assigned_in;
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic [2:0]  err_ff, err_in;

   logic        is_error;
   logic        is_string;

   assign pop = head.valid && (!valid_ff || rsp_bus.ready);

   // field formatting: error-only words carry nothing but the kind and the code
   always_comb begin
      is_error  = (head.data.kind == hbfp_pkg::KIND_ERROR);
      is_string = (head.data.kind == hbfp_pkg::KIND_NAME_BYTE)
               || (head.data.kind == hbfp_pkg::KIND_VALUE_BYTE);

      kind_in     = head.data.kind;
      form_in     = is_error ? hbfp_pkg::FORM_INDEXED : head.data.form;
      index_in    = is_error ? 6'd0 : head.data.name_index;
      assigned_in = (!is_error && head.data.form == hbfp_pkg::FORM_INCREMENTAL)
                  ? head.data.counter : 16'd0;
      byte_in     = is_string ? head.data.str_byte : 8'd0;
      end_in      = is_string && head.data.str_end;
      err_in      = head.data.err;

      valid_in    = pop || (valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   // output word register
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff     <= kind_in;
         form_ff     <= form_in;
         index_ff    <= index_in;
         assigned_ff <= assigned_in;
         byte_ff     <= byte_in;
         end_ff      <= end_in;
         err_ff      <= err_in;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.event_kind     = kind_ff;
   assign rsp_bus.field_form     = form_ff;
   assign rsp_bus.static_index   = index_ff;
   assign rsp_bus.assigned_index = assigned_ff;
   assign rsp_bus.string_byte    = byte_ff;
   assign rsp_bus.string_end     = end_ff;
   assign rsp_bus.error_code     = err_ff;

endmodule

`default_nettype wire

FILE: sv/header_block_field_parser.sv
// header_block_field_parser: top level; parser front, event queue and output stage
// depends on hbfp_pkg, hbfp_req_if, hbfp_rsp_if, hbfp_front, hbfp_queue, hbfp_back
//
//   channel   direction  word contents
//   req_bus   in         block_byte, block_last
//   rsp_bus   out        event_kind, field_form, static_index, assigned_index,
//                        string_byte, string_end, error_code
//   csr_*     in         assigned_index_start (16 bits, write only)
//
// one byte is taken per cycle while the event queue has room; its event, if any, is
// queued at the accepting edge and reaches rsp_bus through the output register
// reset is synchronous; the field counter restarts at zero and req_bus ready stays low
// while reset is high
// a stalled rsp_bus fills the four-word event queue and the output register (five
// events), after which req_bus ready drops
`default_nettype none

module header_block_field_parser #(
   parameter int STATIC_ENTRIES = 61
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hbfp_req_if.sink         req_bus,
   hbfp_rsp_if.source       rsp_bus,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic                     push;
   hbfp_pkg::event_type      push_data;
   logic                     pop;
   logic                     queue_full;
   hbfp_pkg::queue_head_type head;

   // byte parser
   hbfp_front #(
      .STATIC_ENTRIES (STATIC_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .queue_full  (queue_full),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_data   (push_data)
   );

   // event queue
   hbfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .head      (head)
   );

   // output stage
   hbfp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
